[rtl/lcsl_pkg.sv]
package lcsl_pkg;

  localparam int unsigned MAX_LEN_DEF     = 256;
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned VALUE_W         = 32;
  localparam int unsigned LENGTH_W        = 9;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                      op;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } lcsl_in_t;

  typedef struct packed {
    logic [LENGTH_W-1:0] length;
    logic                ref_overflow;
  } lcsl_out_t;

  typedef struct packed {
    logic tok;
    logic last;
  } lcsl_ctl_t;

endpackage

[rtl/longest_common_subsequence_length_core.sv]
// Query items flow through a chain of MAX_LEN cells, one per reference element.
// A query item passes through the register of every cell in turn, and the result of a final query
// item is registered once more at the output. One query item is accepted per cycle unless the
// output holds a finished result under stall. A load item waits until no query item is in the chain.
// Reset clears the DP row, the counters and the overflow and valid flags and sets the
// reference-complete flag; the reference store is not reset.
module longest_common_subsequence_length_core #(
  parameter int unsigned MAX_LEN     = lcsl_pkg::MAX_LEN_DEF,
  parameter int unsigned VALUE_WIDTH = lcsl_pkg::VALUE_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lcsl_pkg::lcsl_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lcsl_pkg::lcsl_out_t out_data_o
);

  localparam int unsigned VW    = (VALUE_WIDTH < lcsl_pkg::VALUE_W) ?
                                  VALUE_WIDTH : lcsl_pkg::VALUE_W;
  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);

  lcsl_pkg::lcsl_ctl_t ctl_s  [MAX_LEN+1];
  logic [VW-1:0]       val_s  [MAX_LEN+1];
  logic [LEN_W-1:0]    left_s [MAX_LEN+1];
  logic [LEN_W-1:0]    diag_s [MAX_LEN+1];

  logic [CNT_W-1:0] ref_count_q, ref_count_d;
  logic [CNT_W-1:0] inflight_q, inflight_d;
  logic             ref_complete_q, ref_complete_d;
  logic             ovf_q, ovf_d;
  logic             out_valid_q, out_valid_d;
  lcsl_pkg::lcsl_out_t out_q;

  logic             en, accept, load_acc, query_acc, take, full;
  logic [CNT_W-1:0] wr_idx;

  assign en = !(ctl_s[MAX_LEN].tok && ctl_s[MAX_LEN].last && out_valid_q && out_stall_i);
  assign in_stall_o = !en ||
                      ((in_data_i.op == lcsl_pkg::OP_LOAD) && (inflight_q != '0));
  assign accept    = in_valid_i && !in_stall_o;
  assign load_acc  = accept && (in_data_i.op == lcsl_pkg::OP_LOAD);
  assign query_acc = accept && (in_data_i.op == lcsl_pkg::OP_QUERY);
  assign take      = en && ctl_s[MAX_LEN].tok && ctl_s[MAX_LEN].last;

  assign wr_idx = ref_complete_q ? '0 : ref_count_q;
  assign full   = (wr_idx == CNT_W'(MAX_LEN));

  assign ctl_s[0].tok  = query_acc;
  assign ctl_s[0].last = in_data_i.last;
  assign val_s[0]      = in_data_i.value[VW-1:0];
  assign left_s[0]     = '0;
  assign diag_s[0]     = '0;

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    lcsl_cell #(
      .VW    (VW),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .clr_i      (load_acc),
      .wr_i       (load_acc && !full && (wr_idx == CNT_W'(j))),
      .wr_value_i (in_data_i.value[VW-1:0]),
      .active_i   (CNT_W'(j) < ref_count_q),
      .ctl_i      (ctl_s[j]),
      .val_i      (val_s[j]),
      .left_i     (left_s[j]),
      .diag_i     (diag_s[j]),
      .ctl_o      (ctl_s[j+1]),
      .val_o      (val_s[j+1]),
      .left_o     (left_s[j+1]),
      .diag_o     (diag_s[j+1])
    );
  end

  always_comb begin
    ref_count_d    = ref_count_q;
    ref_complete_d = ref_complete_q;
    ovf_d          = ovf_q;
    if (load_acc) begin
      ref_count_d    = full ? wr_idx : wr_idx + CNT_W'(1);
      ovf_d          = (ref_complete_q ? 1'b0 : ovf_q) | full;
      ref_complete_d = in_data_i.last;
    end else if (query_acc) begin
      ref_complete_d = 1'b1;
    end
  end

  always_comb begin
    inflight_d = inflight_q;
    if (query_acc) begin
      inflight_d = inflight_d + CNT_W'(1);
    end
    if (en && ctl_s[MAX_LEN].tok) begin
      inflight_d = inflight_d - CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_count_q    <= '0;
      ref_complete_q <= 1'b1;
      ovf_q          <= 1'b0;
      inflight_q     <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      ref_count_q    <= ref_count_d;
      ref_complete_q <= ref_complete_d;
      ovf_q          <= ovf_d;
      inflight_q     <= inflight_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q.length       <= lcsl_pkg::LENGTH_W'(left_s[MAX_LEN]);
      out_q.ref_overflow <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/lcsl_cell.sv]
module lcsl_cell #(
  parameter int unsigned VW    = 32,
  parameter int unsigned LEN_W = 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               clr_i,
  input  logic               wr_i,
  input  logic [VW-1:0]      wr_value_i,
  input  logic               active_i,
  input  lcsl_pkg::lcsl_ctl_t ctl_i,
  input  logic [VW-1:0]      val_i,
  input  logic [LEN_W-1:0]   left_i,
  input  logic [LEN_W-1:0]   diag_i,
  output lcsl_pkg::lcsl_ctl_t ctl_o,
  output logic [VW-1:0]      val_o,
  output logic [LEN_W-1:0]   left_o,
  output logic [LEN_W-1:0]   diag_o
);

  logic [VW-1:0]       ref_q;
  logic [LEN_W-1:0]    dp_q, dp_d;
  logic [LEN_W-1:0]    nv;
  lcsl_pkg::lcsl_ctl_t ctl_q;
  logic [VW-1:0]       val_q;
  logic [LEN_W-1:0]    left_q, diag_q;

  always_comb begin
    if (!active_i) begin
      nv = left_i;
    end else if (ref_q == val_i) begin
      nv = diag_i + LEN_W'(1);
    end else if (dp_q > left_i) begin
      nv = dp_q;
    end else begin
      nv = left_i;
    end
  end

  always_comb begin
    dp_d = dp_q;
    if (clr_i) begin
      dp_d = '0;
    end else if (en_i && ctl_i.tok && active_i) begin
      dp_d = ctl_i.last ? '0 : nv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      ref_q <= wr_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dp_q  <= '0;
      ctl_q <= '0;
    end else begin
      dp_q <= dp_d;
      if (en_i) begin
        ctl_q <= ctl_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q  <= val_i;
      left_q <= nv;
      diag_q <= dp_q;
    end
  end

  assign ctl_o  = ctl_q;
  assign val_o  = val_q;
  assign left_o = left_q;
  assign diag_o = diag_q;

endmodule
